### design/pbk_pkg.sv
// ============================================================================
// pbk_pkg
// Shared types and constants for the per-label best box keeper.
// ============================================================================
package pbk_pkg;

    localparam int LBL_W          = 4;
    localparam int COORD_W        = 16;
    localparam int SCORE_W        = 16;
    localparam int THR_W          = 16;
    localparam int NUM_LABELS_DEF = 16;

    localparam logic [THR_W-1:0] THR_RESET = 16'h8000;

    // command codes
    localparam logic CMD_DETECT = 1'b0;
    localparam logic CMD_FLUSH  = 1'b1;

    typedef struct packed {
        logic               command;
        logic               is_detected;
        logic [LBL_W-1:0]   class_label;
        logic [COORD_W-1:0] box_x;
        logic [COORD_W-1:0] box_y;
        logic [COORD_W-1:0] box_w;
        logic [COORD_W-1:0] box_h;
        logic [SCORE_W-1:0] score;
    } in_item_t;

    typedef struct packed {
        logic               present;
        logic               out_detected;
        logic [LBL_W-1:0]   out_label;
        logic [COORD_W-1:0] out_x;
        logic [COORD_W-1:0] out_y;
        logic [COORD_W-1:0] out_w;
        logic [COORD_W-1:0] out_h;
        logic [SCORE_W-1:0] out_score;
        logic               last;
    } out_item_t;

    typedef struct packed {
        logic [COORD_W-1:0] h;
        logic [COORD_W-1:0] w;
        logic [COORD_W-1:0] y;
        logic [COORD_W-1:0] x;
    } box_t;

    // one table entry
    typedef struct packed {
        logic [SCORE_W-1:0] score;
        box_t               box;
    } entry_t;

    // table access controls
    typedef struct packed {
        logic rd;   // read entry and valid bit at the read index
        logic clr;  // clear valid bit at the read index
        logic wr;   // write entry and set valid bit at the write index
    } tbl_op_t;

endpackage

### design/pbk_table.sv
// ============================================================================
// pbk_table
// Best-box table: one synchronous memory plus one valid flag per label.
// ============================================================================
module pbk_table
    import pbk_pkg::*;
#(
    parameter int NUM_LABELS = NUM_LABELS_DEF,
    localparam int IDX_W     = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  tbl_op_t          op,
    input  logic [IDX_W-1:0] rd_idx,
    input  logic [IDX_W-1:0] wr_idx,
    input  entry_t           wr_data,
    output entry_t           rd_data,
    output logic             rd_valid
);

    entry_t                  mem [NUM_LABELS];
    entry_t                  rd_data_reg;
    logic [NUM_LABELS-1:0]   valid_reg;

    // valid flag seen at the read index, same cycle
    assign rd_valid = valid_reg[rd_idx];
    assign rd_data  = rd_data_reg;

    // valid flags
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            if (op.clr)
            begin
                valid_reg[rd_idx] <= 1'b0;
            end
            if (op.wr)
            begin
                valid_reg[wr_idx] <= 1'b1;
            end
        end
    end

    // entry memory, registered read
    always_ff @(posedge clk)
    begin
        if (op.wr)
        begin
            mem[wr_idx] <= wr_data;
        end
        if (op.rd)
        begin
            rd_data_reg <= mem[rd_idx];
        end
    end

endmodule

### design/pbk_overlap.sv
// ============================================================================
// pbk_overlap
// Three-stage overlap test: inter * 65536 > threshold * enclosing area.
// ============================================================================
module pbk_overlap
    import pbk_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             go,
    input  box_t             stored,
    input  box_t             fresh,
    input  logic [THR_W-1:0] thr,
    output logic             done,
    output logic             exceeds
);

    localparam int EDGE_W = COORD_W + 1;
    localparam int AREA_W = 2 * EDGE_W;
    localparam int PROD_W = AREA_W + THR_W;

    logic [EDGE_W-1:0] ax2, ay2, bx2, by2;
    logic [EDGE_W-1:0] ix2, iy2, ux2, uy2;
    logic [COORD_W-1:0] ix1, iy1, ux1, uy1;
    logic [EDGE_W-1:0] iw_next, ih_next, uw_next, uh_next;

    logic [EDGE_W-1:0] iw_reg, ih_reg, uw_reg, uh_reg;
    logic [AREA_W-1:0] inter_reg, uni_reg, inter_d_reg;
    logic [PROD_W-1:0] thrprod_reg;
    logic              v1_reg, v2_reg, v3_reg;

    // stage 1: edges, intersection and enclosing extents
    always_comb
    begin
        ax2 = {1'b0, stored.x} + {1'b0, stored.w};
        ay2 = {1'b0, stored.y} + {1'b0, stored.h};
        bx2 = {1'b0, fresh.x} + {1'b0, fresh.w};
        by2 = {1'b0, fresh.y} + {1'b0, fresh.h};
        ix1 = (stored.x > fresh.x) ? stored.x : fresh.x;
        iy1 = (stored.y > fresh.y) ? stored.y : fresh.y;
        ix2 = (ax2 < bx2) ? ax2 : bx2;
        iy2 = (ay2 < by2) ? ay2 : by2;
        ux1 = (stored.x < fresh.x) ? stored.x : fresh.x;
        uy1 = (stored.y < fresh.y) ? stored.y : fresh.y;
        ux2 = (ax2 > bx2) ? ax2 : bx2;
        uy2 = (ay2 > by2) ? ay2 : by2;
        // a zero extent in either axis zeroes the intersection area
        iw_next = ({1'b0, ix1} < ix2) ? (ix2 - {1'b0, ix1}) : '0;
        ih_next = ({1'b0, iy1} < iy2) ? (iy2 - {1'b0, iy1}) : '0;
        uw_next = ux2 - {1'b0, ux1};
        uh_next = uy2 - {1'b0, uy1};
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        iw_reg <= iw_next;
        ih_reg <= ih_next;
        uw_reg <= uw_next;
        uh_reg <= uh_next;
        // stage 2: areas
        inter_reg <= {{EDGE_W{1'b0}}, iw_reg} * {{EDGE_W{1'b0}}, ih_reg};
        uni_reg   <= {{EDGE_W{1'b0}}, uw_reg} * {{EDGE_W{1'b0}}, uh_reg};
        // stage 3: scaled enclosing area
        thrprod_reg <= {{AREA_W{1'b0}}, thr} * {{THR_W{1'b0}}, uni_reg};
        inter_d_reg <= inter_reg;
    end

    // stage valids
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else
        begin
            v1_reg <= go;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    assign done    = v3_reg;
    assign exceeds = {inter_d_reg, {THR_W{1'b0}}} > thrprod_reg;

endmodule

### design/per_label_best_box_keeper_unit.sv
// Pass-through item: result in the cycle after acceptance, busy stays low.
// Detected item: an empty label is stored at once and a label out of range is
// dropped, busy staying low; otherwise busy through table read, 3-stage overlap test, write back.
// Flush: busy through S_FLUSH, S_FTAIL and S_FEND, one table entry read per cycle through
// the single memory read port; results are strobed and cannot be stalled.
// Reset clears all valid flags at once and sets the threshold to 0.5.
// ============================================================================
// per_label_best_box_keeper_unit
// Keeps the best box per class label for a frame and emits them on flush.
// ============================================================================
module per_label_best_box_keeper_unit
    import pbk_pkg::*;
#(
    parameter int NUM_LABELS = NUM_LABELS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  in_item_t         item,
    input  logic             cfg_we,
    input  logic [THR_W-1:0] cfg_wdata,
    output logic             result_valid,
    output out_item_t        result
);

    localparam int IDX_W = (NUM_LABELS > 1) ? $clog2(NUM_LABELS) : 1;
    localparam int EXT_W = IDX_W + LBL_W;

    typedef enum logic [4:0] {
        S_IDLE  = 5'b00001,
        S_OVL   = 5'b00010,
        S_FLUSH = 5'b00100,
        S_FTAIL = 5'b01000,
        S_FEND  = 5'b10000
    } state_t;

    state_t           state_reg, state_next;
    in_item_t         item_reg;
    logic [THR_W-1:0] thr_reg;
    logic [IDX_W-1:0] scan_reg;
    logic             go_reg;
    logic             proc_en_reg, proc_vld_reg;
    logic [IDX_W-1:0] proc_idx_reg;
    logic             pend_valid_reg, pend_valid_next;
    out_item_t        pend_reg, pend_next;
    logic             res_valid_reg, res_valid_next;
    out_item_t        res_reg, res_next;

    logic             acc;
    logic [EXT_W-1:0] in_ext, held_ext, proc_ext;
    logic [IDX_W-1:0] in_idx, held_idx;
    logic             in_range;
    tbl_op_t          op;
    logic [IDX_W-1:0] rd_idx, wr_idx;
    entry_t           wr_data, rd_data;
    logic             rd_valid;
    logic             ovl_done, ovl_exceeds;
    logic             go_next;
    in_item_t         wr_src;

    // label to table index
    always_comb
    begin
        in_ext   = {{IDX_W{1'b0}}, item.class_label};
        held_ext = {{IDX_W{1'b0}}, item_reg.class_label};
        proc_ext = {{LBL_W{1'b0}}, proc_idx_reg};
        in_idx   = in_ext[IDX_W-1:0];
        held_idx = held_ext[IDX_W-1:0];
        in_range = 32'(item.class_label) < 32'(NUM_LABELS);
    end

    assign acc  = start && (state_reg == S_IDLE);
    assign busy = (state_reg != S_IDLE);

    // control, table access and result selection
    always_comb
    begin
        state_next      = state_reg;
        op              = '0;
        rd_idx          = in_idx;
        wr_idx          = in_idx;
        wr_src          = item;
        go_next         = 1'b0;
        res_valid_next  = 1'b0;
        res_next        = res_reg;
        pend_valid_next = pend_valid_reg;
        pend_next       = pend_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (acc)
                begin
                    if (item.command == CMD_FLUSH)
                    begin
                        state_next      = S_FLUSH;
                        pend_valid_next = 1'b0;
                    end
                    else if (!item.is_detected)
                    begin
                        res_valid_next         = 1'b1;
                        res_next.present       = 1'b1;
                        res_next.out_detected  = 1'b0;
                        res_next.out_label     = item.class_label;
                        res_next.out_x         = item.box_x;
                        res_next.out_y         = item.box_y;
                        res_next.out_w         = item.box_w;
                        res_next.out_h         = item.box_h;
                        res_next.out_score     = item.score;
                        res_next.last          = 1'b1;
                    end
                    else if (in_range)
                    begin
                        op.rd = 1'b1;
                        if (!rd_valid)
                        begin
                            // empty label: store straight away
                            op.wr = 1'b1;
                        end
                        else
                        begin
                            go_next    = 1'b1;
                            state_next = S_OVL;
                        end
                    end
                end
            end
            S_OVL:
            begin
                wr_idx = held_idx;
                wr_src = item_reg;
                if (ovl_done)
                begin
                    op.wr      = !ovl_exceeds && (rd_data.score < item_reg.score);
                    state_next = S_IDLE;
                end
            end
            S_FLUSH:
            begin
                op.rd  = 1'b1;
                op.clr = 1'b1;
                rd_idx = scan_reg;
                if (scan_reg == IDX_W'(NUM_LABELS - 1))
                begin
                    state_next = S_FTAIL;
                end
            end
            S_FTAIL:
            begin
                state_next = S_FEND;
            end
            S_FEND:
            begin
                state_next      = S_IDLE;
                res_valid_next  = 1'b1;
                pend_valid_next = 1'b0;
                if (pend_valid_reg)
                begin
                    res_next      = pend_reg;
                    res_next.last = 1'b1;
                end
                else
                begin
                    res_next      = '0;
                    res_next.last = 1'b1;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // flush entry arriving from the table: hold it back one step so the
        // final one can be marked last
        if (proc_en_reg && proc_vld_reg)
        begin
            if (pend_valid_reg)
            begin
                res_valid_next = 1'b1;
                res_next       = pend_reg;
            end
            pend_valid_next        = 1'b1;
            pend_next.present      = 1'b1;
            pend_next.out_detected = 1'b1;
            pend_next.out_label    = proc_ext[LBL_W-1:0];
            pend_next.out_x        = rd_data.box.x;
            pend_next.out_y        = rd_data.box.y;
            pend_next.out_w        = rd_data.box.w;
            pend_next.out_h        = rd_data.box.h;
            pend_next.out_score    = rd_data.score;
            pend_next.last         = 1'b0;
        end
    end

    // entry written back
    always_comb
    begin
        wr_data.box.x = wr_src.box_x;
        wr_data.box.y = wr_src.box_y;
        wr_data.box.w = wr_src.box_w;
        wr_data.box.h = wr_src.box_h;
        wr_data.score = wr_src.score;
    end

    // control state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            thr_reg        <= THR_RESET;
            scan_reg       <= '0;
            go_reg         <= 1'b0;
            proc_en_reg    <= 1'b0;
            pend_valid_reg <= 1'b0;
            res_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            go_reg         <= go_next;
            proc_en_reg    <= (state_reg == S_FLUSH);
            pend_valid_reg <= pend_valid_next;
            res_valid_reg  <= res_valid_next;
            if (cfg_we)
            begin
                thr_reg <= cfg_wdata;
            end
            if (state_reg == S_FLUSH)
            begin
                scan_reg <= (scan_reg == IDX_W'(NUM_LABELS - 1)) ? '0 : scan_reg + 1'b1;
            end
        end
    end

    // payload
    always_ff @(posedge clk)
    begin
        if (acc)
        begin
            item_reg <= item;
        end
        proc_vld_reg <= rd_valid;
        proc_idx_reg <= scan_reg;
        pend_reg     <= pend_next;
        res_reg      <= res_next;
    end

    assign result_valid = res_valid_reg;
    assign result       = res_reg;

    pbk_table #(
        .NUM_LABELS (NUM_LABELS)
    ) u_table (
        .clk      (clk),
        .rst_n    (rst_n),
        .op       (op),
        .rd_idx   (rd_idx),
        .wr_idx   (wr_idx),
        .wr_data  (wr_data),
        .rd_data  (rd_data),
        .rd_valid (rd_valid)
    );

    pbk_overlap u_overlap (
        .clk     (clk),
        .rst_n   (rst_n),
        .go      (go_reg),
        .stored  (rd_data.box),
        .fresh   ({item_reg.box_h, item_reg.box_w, item_reg.box_y, item_reg.box_x}),
        .thr     (thr_reg),
        .done    (ovl_done),
        .exceeds (ovl_exceeds)
    );

endmodule

### design/pbk_checker.sv
// ============================================================================
// pbk_checker
// Port-level checks on the best box keeper, bound to the top level.
// ============================================================================
module pbk_checker
    import pbk_pkg::*;
(
    input logic             clk,
    input logic             rst_n,
    input logic             start,
    input logic             busy,
    input in_item_t         item,
    input logic             result_valid,
    input out_item_t        result
);

    // an empty flush result always closes the item
    a_empty_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && !result.present |-> result.last)
        else $error("empty result not marked last");

    // a passed-through item is a single result
    a_pass_last: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.present && !result.out_detected |-> result.last)
        else $error("pass-through result not marked last");

    // an undetected item comes back on the next cycle
    a_pass_timing: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_DETECT && !item.is_detected
        |=> result_valid && !result.out_detected && result.present)
        else $error("pass-through result missing");

    // a flush occupies the block
    a_flush_busy: assert property (@(posedge clk) disable iff (!rst_n)
        start && !busy && item.command == CMD_FLUSH |=> busy)
        else $error("flush did not raise busy");

endmodule

bind per_label_best_box_keeper_unit pbk_checker u_pbk_checker (.*);
